[rtl/gsf_pkg.sv]
`timescale 1ns / 1ps
// shared constants, types and kernel weights for the gaussian smoothing filter
package gsf_pkg;

   localparam int MAX_WIDTH    = 1024;
   localparam int MAX_HEIGHT   = 4096;
   localparam int PIX_W        = 8;
   localparam int COL_W        = $clog2(MAX_WIDTH);
   localparam int ROW_W        = $clog2(MAX_HEIGHT);
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int WCMP_W       = (COL_W + 1 > WIDTH_REG_W) ? COL_W + 1 : WIDTH_REG_W;
   localparam int HCMP_W       = (ROW_W + 1 > HEIGHT_REG_W) ? ROW_W + 1 : HEIGHT_REG_W;

   localparam int WIN_N    = 5;
   localparam int LB_ROWS  = WIN_N - 1;
   localparam int KS_SMALL = 3;
   localparam int KS_LARGE = 5;

   localparam int WGT_W       = 6;
   localparam int PSUM_W      = 15;
   localparam int SUM_W       = 17;
   localparam int PROD_W      = 34;
   localparam int RECIP_SHIFT = 25;
   localparam int DIV16_SHIFT = RECIP_SHIFT - 4;
   localparam logic [SUM_W-1:0] RECIP_273 = SUM_W'(122911);

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RST  = WIDTH_REG_W'(640);
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RST = HEIGHT_REG_W'(480);

   typedef enum logic [1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_KERNEL_MODE  = 2'd2
   } csr_index_type;

   typedef logic [WIN_N-1:0][PIX_W-1:0]   pix_col_type;
   typedef logic [WIN_N-1:0][WGT_W-1:0]   wcol_type;
   typedef logic [PSUM_W-1:0]             psum_type;
   typedef logic [LB_ROWS-1:0][PIX_W-1:0] lb_word_type;

   typedef struct packed {
      logic shift;
      logic load;
      logic mode;
   } gsf_cell_ctl_type;

   typedef struct packed {
      logic last;
      logic mode;
   } gsf_meta_type;

   typedef struct packed {
      logic             emit;
      gsf_meta_type     meta;
      logic [COL_W-1:0] col;
      logic [PIX_W-1:0] px;
   } gsf_s1_type;

   // weights per window column, row 0 (oldest line) in the low slot
   localparam wcol_type K5_COLS [WIN_N] = '{
      {6'd1, 6'd4,  6'd7,  6'd4,  6'd1},
      {6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
      {6'd7, 6'd26, 6'd41, 6'd26, 6'd7},
      {6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
      {6'd1, 6'd4,  6'd7,  6'd4,  6'd1}
   };

   // 3x3 kernel sits in the bottom-right corner of the window
   localparam wcol_type K3_COLS [WIN_N] = '{
      {6'd0, 6'd0, 6'd0, 6'd0, 6'd0},
      {6'd0, 6'd0, 6'd0, 6'd0, 6'd0},
      {6'd1, 6'd2, 6'd1, 6'd0, 6'd0},
      {6'd2, 6'd4, 6'd2, 6'd0, 6'd0},
      {6'd1, 6'd2, 6'd1, 6'd0, 6'd0}
   };

endpackage

[rtl/gaussian_smoothing_filter_top.sv]
`timescale 1ns / 1ps
// top level: register port, counters, line store, cell chain, sum and divide
// path: a pixel passes stages s1 to s5 and the output register before rsp
// throughput: one pixel per clock while rsp_ready holds, set by the single
//   read-modify-write of the line store per column and the five-cell window chain
// reset: registers return to 640 x 480 and the 3x3 kernel, counters and window
//   clear at once; the line store is not cleared and needs no clearing pass
module gaussian_smoothing_filter_top
   import gsf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [PIX_W-1:0]      req_pixel_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [PIX_W-1:0]      rsp_smooth_pixel,
   output logic                  rsp_frame_last,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam logic [SUM_W-1:0] MAX_SUM5 = SUM_W'(69615);
   localparam logic [SUM_W-1:0] MAX_SUM3 = SUM_W'(4080);

   logic [WIDTH_REG_W-1:0]  width_ff;
   logic [HEIGHT_REG_W-1:0] height_ff;
   logic                    mode_ff;
   logic                    csr_wr;
   csr_index_type           csr_idx;

   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [WCMP_W-1:0] eff_w, width_ext, col_ext;
   logic [HCMP_W-1:0] eff_h, height_ext, row_ext;
   logic              col_wrap, row_wrap, emit, frame_end, big_kernel;

   logic         req_accept;
   logic         out_free, s5_free, s4_free, s3_free, s2_free, s1_free;
   logic         s1_go, s2_go, s3_go, s4_go, s5_go;
   logic         s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff, s5_vld_ff, rsp_valid_ff;
   gsf_s1_type   s1_ff, s1_in;
   gsf_meta_type s2_ff, s3_ff, s4_ff, s5_ff;

   lb_word_type lb_rd, lb_wr;
   pix_col_type lb_col;
   pix_col_type chain [WIN_N+1];
   psum_type    psum [WIN_N];
   gsf_cell_ctl_type cell_ctl;

   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [PIX_W-1:0]  pix_out_ff;
   logic              last_out_ff;

   // register port
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
         mode_ff   <= 1'b0;
      end else if (csr_wr) begin
         case (csr_idx)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_pwdata[WIDTH_REG_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_pwdata[HEIGHT_REG_W-1:0];
            CSR_KERNEL_MODE:  mode_ff   <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_IMAGE_WIDTH:  csr_prdata = CSR_DATA_W'(width_ff);
         CSR_IMAGE_HEIGHT: csr_prdata = CSR_DATA_W'(height_ff);
         CSR_KERNEL_MODE:  csr_prdata = CSR_DATA_W'(mode_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // effective frame size and position
   always_comb begin
      width_ext  = WCMP_W'(width_ff);
      height_ext = HCMP_W'(height_ff);
      if (width_ext > WCMP_W'(MAX_WIDTH)) begin
         eff_w = WCMP_W'(MAX_WIDTH);
      end else if (width_ext == '0) begin
         eff_w = WCMP_W'(1);
      end else begin
         eff_w = width_ext;
      end
      if (height_ext > HCMP_W'(MAX_HEIGHT)) begin
         eff_h = HCMP_W'(MAX_HEIGHT);
      end else if (height_ext == '0) begin
         eff_h = HCMP_W'(1);
      end else begin
         eff_h = height_ext;
      end
   end

   assign col_ext    = WCMP_W'(col_ff);
   assign row_ext    = HCMP_W'(row_ff);
   assign big_kernel = mode_ff;
   assign col_wrap   = (col_ext + WCMP_W'(1)) >= eff_w;
   assign row_wrap   = (row_ext + HCMP_W'(1)) >= eff_h;
   assign frame_end  = (col_ext == eff_w - WCMP_W'(1)) && (row_ext == eff_h - HCMP_W'(1));

   always_comb begin
      if (big_kernel) begin
         emit = ((col_ext + WCMP_W'(1)) >= WCMP_W'(KS_LARGE))
             && ((row_ext + HCMP_W'(1)) >= HCMP_W'(KS_LARGE));
      end else begin
         emit = ((col_ext + WCMP_W'(1)) >= WCMP_W'(KS_SMALL))
             && ((row_ext + HCMP_W'(1)) >= HCMP_W'(KS_SMALL));
      end
      emit = emit && (col_ext < eff_w) && (row_ext < eff_h);
   end

   always_comb begin
      if (col_wrap) begin
         col_in = '0;
         row_in = row_wrap ? '0 : row_ff + ROW_W'(1);
      end else begin
         col_in = col_ff + COL_W'(1);
         row_in = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // pipeline flow
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign s5_free    = !s5_vld_ff || out_free;
   assign s4_free    = !s4_vld_ff || s5_free;
   assign s3_free    = !s3_vld_ff || s4_free;
   assign s2_free    = !s2_vld_ff || s3_free;
   assign s1_free    = !s1_vld_ff || s2_free;
   assign s1_go      = s1_vld_ff && s2_free;
   assign s2_go      = s2_vld_ff && s3_free;
   assign s3_go      = s3_vld_ff && s4_free;
   assign s4_go      = s4_vld_ff && s5_free;
   assign s5_go      = s5_vld_ff && out_free;
   assign req_ready  = s1_free;
   assign req_accept = req_valid && req_ready;

   assign s1_in.emit      = emit;
   assign s1_in.meta.last = frame_end;
   assign s1_in.meta.mode = mode_ff;
   assign s1_in.col       = col_ff;
   assign s1_in.px        = req_pixel_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         s3_vld_ff    <= 1'b0;
         s4_vld_ff    <= 1'b0;
         s5_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_free) begin
            s1_vld_ff <= req_valid;
         end
         if (s2_free) begin
            s2_vld_ff <= s1_go && s1_ff.emit;
         end
         if (s3_free) begin
            s3_vld_ff <= s2_vld_ff;
         end
         if (s4_free) begin
            s4_vld_ff <= s3_vld_ff;
         end
         if (s5_free) begin
            s5_vld_ff <= s4_vld_ff;
         end
         if (out_free) begin
            rsp_valid_ff <= s5_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ff <= s1_in;
      end
      if (s1_go) begin
         s2_ff <= s1_ff.meta;
      end
      if (s2_go) begin
         s3_ff <= s2_ff;
      end
      if (s3_go) begin
         s4_ff  <= s3_ff;
         sum_ff <= sum_in;
      end
      if (s4_go) begin
         s5_ff   <= s4_ff;
         prod_ff <= prod_in;
      end
      if (s5_go) begin
         pix_out_ff  <= prod_ff[RECIP_SHIFT+PIX_W-1:RECIP_SHIFT];
         last_out_ff <= s5_ff.last;
      end
   end

   // line store and window column
   gsf_linebuf u_linebuf (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept),
      .rd_addr (col_ff),
      .wr_en   (s1_go),
      .wr_addr (s1_ff.col),
      .wr_data (lb_wr),
      .rd_data (lb_rd)
   );

   always_comb begin
      lb_wr[0] = s1_ff.px;
      for (int k = 1; k < LB_ROWS; k++) begin
         lb_wr[k] = lb_rd[k-1];
      end
      for (int r = 0; r < LB_ROWS; r++) begin
         lb_col[r] = lb_rd[LB_ROWS-1-r];
      end
      lb_col[WIN_N-1] = s1_ff.px;
   end

   assign chain[WIN_N] = lb_col;

   assign cell_ctl.shift = s1_go;
   assign cell_ctl.load  = s2_go;
   assign cell_ctl.mode  = s2_ff.mode;

   for (genvar i = 0; i < WIN_N; i++) begin : g_cell
      if (i == 0) begin : g_head
         gsf_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .ctl     (cell_ctl),
            .col_in  (chain[i+1]),
            .col_out (),
            .w5      (K5_COLS[i]),
            .w3      (K3_COLS[i]),
            .psum    (psum[i])
         );
         assign chain[i] = '0;
      end else begin : g_body
         gsf_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .ctl     (cell_ctl),
            .col_in  (chain[i+1]),
            .col_out (chain[i]),
            .w5      (K5_COLS[i]),
            .w3      (K3_COLS[i]),
            .psum    (psum[i])
         );
      end
   end

   // window sum and divide
   always_comb begin
      sum_in = '0;
      for (int i = 0; i < WIN_N; i++) begin
         sum_in = sum_in + SUM_W'(psum[i]) + SUM_W'(chain[0][i]);
      end
   end

   always_comb begin
      if (s4_ff.mode) begin
         prod_in = PROD_W'(sum_ff) * PROD_W'(RECIP_273);
      end else begin
         prod_in = PROD_W'(sum_ff) << DIV16_SHIFT;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_smooth_pixel = pix_out_ff;
   assign rsp_frame_last   = last_out_ff;

   a_last_wraps: assert property (@(posedge clock) disable iff (reset)
      (req_accept && s1_in.emit && s1_in.meta.last) |=> (col_ff == '0 && row_ff == '0))
      else $error("counters did not wrap after the last pixel of a frame");

   a_rsp_from_s5: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s5_vld_ff))
      else $error("result appeared without a finished divide stage");

   a_sum5_bound: assert property (@(posedge clock) disable iff (reset)
      (s4_vld_ff && s4_ff.mode) |-> (sum_ff <= MAX_SUM5))
      else $error("5x5 window sum out of range");

   a_sum3_bound: assert property (@(posedge clock) disable iff (reset)
      (s4_vld_ff && !s4_ff.mode) |-> (sum_ff <= MAX_SUM3))
      else $error("3x3 window sum out of range");

endmodule

[rtl/gsf_linebuf.sv]
`timescale 1ns / 1ps
// line store: four previous rows per column, one read and one write per cycle
module gsf_linebuf
   import gsf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [COL_W-1:0] rd_addr,
   input  logic             wr_en,
   input  logic [COL_W-1:0] wr_addr,
   input  lb_word_type      wr_data,
   output lb_word_type      rd_data
);

   lb_word_type mem [MAX_WIDTH];
   lb_word_type rd_ff;
   lb_word_type byp_data_ff;
   logic        byp_ff;
   logic        byp_in;

   assign byp_in = wr_en && (wr_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff       <= mem[rd_addr];
         byp_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else if (rd_en) begin
         byp_ff <= byp_in;
      end
   end

   assign rd_data = byp_ff ? byp_data_ff : rd_ff;

endmodule

[rtl/gsf_cell.sv]
`timescale 1ns / 1ps
// window cell: one window column and its weighted column sum
module gsf_cell
   import gsf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  gsf_cell_ctl_type ctl,
   input  pix_col_type      col_in,
   output pix_col_type      col_out,
   input  wcol_type         w5,
   input  wcol_type         w3,
   output psum_type         psum
);

   pix_col_type col_ff;
   psum_type    psum_ff;
   psum_type    psum_in;
   psum_type    acc5;
   psum_type    acc3;

   always_comb begin
      acc5 = '0;
      acc3 = '0;
      for (int r = 0; r < WIN_N; r++) begin
         acc5 = acc5 + psum_type'(col_ff[r]) * psum_type'(w5[r]);
         // rows outside the small kernel stay out of its sum
         if (w3[r] != '0) begin
            acc3 = acc3 + psum_type'(col_ff[r]) * psum_type'(w3[r]);
         end
      end
      psum_in = ctl.mode ? acc5 : acc3;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else if (ctl.shift) begin
         col_ff <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         psum_ff <= psum_in;
      end
   end

   assign col_out = col_ff;
   assign psum    = psum_ff;

endmodule
